// ===== rtl/core/dwar_pkg.sv =====
// Package: shared constants, request types and answer byte table for the DNS responder.
`timescale 1ns / 1ps
package dwar_pkg;

  localparam int MAX_PACKET = 256;
  localparam int POS_W      = $clog2(MAX_PACKET + 1);
  localparam int HDR_LEN    = 12;
  localparam int MIN_LEN    = HDR_LEN + 5;
  localparam int ANSWER_LEN = 16;
  localparam int ANS_W      = $clog2(ANSWER_LEN);
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = $clog2(Q_DEPTH);

  localparam logic [7:0]  OPCODE_MASK_HI = 8'h78;
  localparam logic [7:0]  LABEL_PTR_BITS = 8'hC0;
  localparam logic [7:0]  LABEL_MAX      = 8'd63;
  localparam logic [15:0] REPLY_FLAGS    = 16'h8180;
  localparam logic [15:0] NAME_POINTER   = 16'hC00C;
  localparam logic [31:0] TTL_RESET      = 32'd60;

  localparam logic [2:0] V_OK     = 3'd0;
  localparam logic [2:0] V_LENGTH = 3'd1;
  localparam logic [2:0] V_HEADER = 3'd2;
  localparam logic [2:0] V_NAME   = 3'd3;
  localparam logic [2:0] V_TYPE   = 3'd4;

  localparam logic REG_ADDRESS = 1'b0;
  localparam logic REG_TTL     = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } query_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_end;
    logic [2:0] verdict;
  } reply_t;

  typedef struct packed {
    reply_t res;
    logic   append;
  } q_entry_t;

  function automatic logic [7:0] answer_byte(input logic [ANS_W-1:0] idx,
                                             input logic [31:0] ttl,
                                             input logic [31:0] addr);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      4'd0:    b = NAME_POINTER[15:8];
      4'd1:    b = NAME_POINTER[7:0];
      4'd3:    b = 8'h01;
      4'd5:    b = 8'h01;
      4'd6:    b = ttl[31:24];
      4'd7:    b = ttl[23:16];
      4'd8:    b = ttl[15:8];
      4'd9:    b = ttl[7:0];
      4'd11:   b = 8'h04;
      4'd12:   b = addr[31:24];
      4'd13:   b = addr[23:16];
      4'd14:   b = addr[15:8];
      4'd15:   b = addr[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/core/dwar_front.sv =====
// Front end: accepts query bytes, rewrites the header, parses the question, forms the verdict.
`timescale 1ns / 1ps
module dwar_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  dwar_pkg::query_t  query,
  output dwar_pkg::q_entry_t entry
);
  import dwar_pkg::*;

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [POS_W-1:0] next_label_position, next_label_position_next;
  logic             name_finished, name_finished_next;
  logic [POS_W-1:0] name_end_position, name_end_position_next;
  logic [15:0]      query_type, query_type_next;
  logic [2:0]       error_code, error_code_next;

  logic [POS_W-1:0] pos;
  logic [7:0]       b;
  logic [7:0]       ob;
  logic [2:0]       v;
  logic [POS_W:0]   end_plus5;

  assign pos = byte_position;
  assign b   = query.in_byte;

  always_comb begin
    ob                       = b;
    byte_position_next       = byte_position;
    next_label_position_next = next_label_position;
    name_finished_next       = name_finished;
    name_end_position_next   = name_end_position;
    query_type_next          = query_type;
    error_code_next          = error_code;
    if (pos < POS_W'(MAX_PACKET)) begin
      case (pos) inside
        POS_W'(2): begin
          if ((b & OPCODE_MASK_HI) != 8'h00 && error_code_next == V_OK) begin
            error_code_next = V_HEADER;
          end
          ob = REPLY_FLAGS[15:8];
        end
        POS_W'(3): ob = REPLY_FLAGS[7:0];
        POS_W'(4): begin
          if (b != 8'h00 && error_code_next == V_OK) begin
            error_code_next = V_HEADER;
          end
        end
        POS_W'(5): begin
          if (b != 8'h01 && error_code_next == V_OK) begin
            error_code_next = V_HEADER;
          end
        end
        POS_W'(6): ob = 8'h00;
        POS_W'(7): ob = 8'h01;
        [POS_W'(8):POS_W'(11)]: ob = 8'h00;
        default: ob = b;
      endcase
      if (pos >= POS_W'(HDR_LEN) && !name_finished && error_code_next == V_OK &&
          pos == next_label_position) begin
        if (b == 8'h00) begin
          name_finished_next     = 1'b1;
          name_end_position_next = pos;
        end else if ((b & LABEL_PTR_BITS) != 8'h00 || b > LABEL_MAX) begin
          error_code_next = V_NAME;
        end else begin
          next_label_position_next = pos + POS_W'(1) + POS_W'(b);
        end
      end else if (name_finished && pos == name_end_position + POS_W'(1)) begin
        query_type_next = {b, query_type[7:0]};
      end else if (name_finished && pos == name_end_position + POS_W'(2)) begin
        query_type_next = {query_type[15:8], b};
      end
      byte_position_next = pos + POS_W'(1);
    end
  end

  assign end_plus5 = {1'b0, name_end_position_next} + (POS_W + 1)'(5);

  always_comb begin
    if (byte_position_next < POS_W'(MIN_LEN) ||
        byte_position_next > POS_W'(MAX_PACKET - 16)) begin
      v = V_LENGTH;
    end else if (error_code_next != V_OK) begin
      v = error_code_next;
    end else if (!name_finished_next || end_plus5 > {1'b0, byte_position_next}) begin
      v = V_NAME;
    end else if (query_type_next != 16'd1) begin
      v = V_TYPE;
    end else begin
      v = V_OK;
    end
  end

  always_comb begin
    entry.res.out_byte = ob;
    entry.res.out_end  = query.in_last && (v != V_OK);
    entry.res.verdict  = query.in_last ? v : V_OK;
    entry.append       = query.in_last && (v == V_OK);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && query.in_last)) begin
      byte_position       <= '0;
      next_label_position <= POS_W'(HDR_LEN);
      name_finished       <= 1'b0;
      name_end_position   <= '0;
      query_type          <= '0;
      error_code          <= V_OK;
    end else if (accept) begin
      byte_position       <= byte_position_next;
      next_label_position <= next_label_position_next;
      name_finished       <= name_finished_next;
      name_end_position   <= name_end_position_next;
      query_type          <= query_type_next;
      error_code          <= error_code_next;
    end
  end

endmodule

// ===== rtl/core/dwar_queue.sv =====
// Short queue between the parsing front end and the reply back end.
`timescale 1ns / 1ps
module dwar_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  dwar_pkg::q_entry_t  wdata,
  output logic                full,
  input  logic                rd,
  output dwar_pkg::q_entry_t  rdata,
  output logic                empty
);
  import dwar_pkg::*;

  q_entry_t        mem [Q_DEPTH];
  logic [Q_AW-1:0] wptr;
  logic [Q_AW-1:0] rptr;
  logic [Q_AW:0]   count;

  assign full  = (count == (Q_AW + 1)'(Q_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + Q_AW'(1);
      end
      if (rd) begin
        rptr <= rptr + Q_AW'(1);
      end
      case ({wr, rd})
        2'b10:   count <= count + (Q_AW + 1)'(1);
        2'b01:   count <= count - (Q_AW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/dwar_back.sv =====
// Back end: drains the queue into the output register and appends the answer record.
`timescale 1ns / 1ps
module dwar_back (
  input  logic               clk,
  input  logic               rst,
  input  dwar_pkg::q_entry_t q_data,
  input  logic               q_empty,
  output logic               q_rd,
  input  logic [31:0]        answer_ttl,
  input  logic [31:0]        answer_address,
  input  logic               pop,
  output logic               empty,
  output dwar_pkg::reply_t   reply
);
  import dwar_pkg::*;

  typedef enum logic [1:0] {
    ST_PASS   = 2'b01,
    ST_ANSWER = 2'b10
  } state_t;

  state_t           state;
  logic [ANS_W-1:0] idx;
  logic             out_valid;
  logic             load_ok;

  assign load_ok = !out_valid || pop;
  assign q_rd    = (state == ST_PASS) && !q_empty && load_ok;
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_PASS;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_PASS: begin
          if (q_rd) begin
            out_valid <= 1'b1;
            if (q_data.append) begin
              state <= ST_ANSWER;
              idx   <= '0;
            end
          end else if (pop) begin
            out_valid <= 1'b0;
          end
        end
        ST_ANSWER: begin
          if (load_ok) begin
            out_valid <= 1'b1;
            idx       <= idx + ANS_W'(1);
            if (idx == ANS_W'(ANSWER_LEN - 1)) begin
              state <= ST_PASS;
            end
          end
        end
        default: state <= ST_PASS;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      reply <= q_data.res;
    end else if (state == ST_ANSWER && load_ok) begin
      reply.out_byte <= answer_byte(idx, answer_ttl, answer_address);
      reply.out_end  <= (idx == ANS_W'(ANSWER_LEN - 1));
      reply.verdict  <= V_OK;
    end
  end

endmodule

// ===== rtl/core/dns_wildcard_a_responder_core.sv =====
// Top level: register port, front end, queue and back end of the wildcard A responder.
// Throughput: 1 byte per cycle while pop is high; a valid query adds 16 answer bytes,
// during which the back end takes nothing from the 4-entry queue, so input stalls once
// the queue fills. Bytes reach the reply port via the queue and the output register.
// Reset (rst, synchronous): parser state cleared, queue and output empty,
// answer_address = 0, answer_ttl = 60.
`timescale 1ns / 1ps
module dns_wildcard_a_responder_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  dwar_pkg::query_t query,
  output logic             empty,
  input  logic             pop,
  output dwar_pkg::reply_t reply,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import dwar_pkg::*;

  logic [31:0] answer_address;
  logic [31:0] answer_ttl;
  logic        accept;
  q_entry_t    f_entry;
  q_entry_t    q_data;
  logic        q_empty;
  logic        q_rd;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TTL) ? answer_ttl : answer_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      answer_address <= '0;
      answer_ttl     <= TTL_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_ADDRESS) begin
        answer_address <= pwdata;
      end else begin
        answer_ttl <= pwdata;
      end
    end
  end

  assign accept = push && !full;

  dwar_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .query  (query),
    .entry  (f_entry)
  );

  dwar_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (accept),
    .wdata (f_entry),
    .full  (full),
    .rd    (q_rd),
    .rdata (q_data),
    .empty (q_empty)
  );

  dwar_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_data         (q_data),
    .q_empty        (q_empty),
    .q_rd           (q_rd),
    .answer_ttl     (answer_ttl),
    .answer_address (answer_address),
    .pop            (pop),
    .empty          (empty),
    .reply          (reply)
  );

endmodule

// ===== tb/dns_wildcard_a_responder_core_tb.sv =====
// Testbench: byte-stream queries with a predicted reply stream and APB register updates.
`timescale 1ns / 1ps
module dns_wildcard_a_responder_core_tb;
  import dwar_pkg::*;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 4;
  localparam int          RANDOM_ITEMS   = 130;
  localparam int          HOLD_CYCLES    = 150;
  localparam logic [15:0] QTYPE_A        = 16'h0001;
  localparam logic [15:0] QCLASS_IN      = 16'h0001;
  localparam logic [15:0] OPCODE_FLAGS   = {OPCODE_MASK_HI, 8'h00};
  localparam logic [2:0]  ADDR_ADDRESS   = {REG_ADDRESS, 2'b00};
  localparam logic [2:0]  ADDR_TTL       = {REG_TTL, 2'b00};

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        push    = 1'b0;
  logic        full;
  query_t      query   = '0;
  logic        empty;
  logic        pop     = 1'b0;
  reply_t      reply;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  dns_wildcard_a_responder_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .query   (query),
    .empty   (empty),
    .pop     (pop),
    .reply   (reply),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [31:0] cfg_address = 32'd0;
  logic [31:0] cfg_ttl     = TTL_RESET;
  int unsigned q_pos       = 0;
  int unsigned q_label_at  = HDR_LEN;
  int unsigned q_name_end  = 0;
  bit          q_name_done = 1'b0;
  logic [15:0] q_type      = '0;
  logic [2:0]  q_err       = V_OK;

  reply_t     pending_replies[$];
  logic [7:0] pkt[$];
  int         mismatches  = 0;
  int         bytes_sent  = 0;
  int         idle_cycles = 0;
  int         rx_hold_req = 0;
  bit         tx_idle_en  = 1'b1;
  bit         rx_idle_en  = 1'b1;

  function automatic reply_t build_reply(input logic [7:0] b, input logic e,
                                         input logic [2:0] v);
    reply_t r;
    r.out_byte = b;
    r.out_end  = e;
    r.verdict  = v;
    return r;
  endfunction

  function automatic logic [7:0] answer_field(input int idx);
    logic [127:0] rec;
    rec = {NAME_POINTER, QTYPE_A, QCLASS_IN, cfg_ttl, 16'd4, cfg_address};
    return rec[127 - 8*idx -: 8];
  endfunction

  function automatic logic [2:0] query_verdict(input int unsigned len);
    if (len < MIN_LEN || len > MAX_PACKET - 16) return V_LENGTH;
    if (q_err != V_OK) return q_err;
    if (!q_name_done || q_name_end + 5 > len) return V_NAME;
    if (q_type != QTYPE_A) return V_TYPE;
    return V_OK;
  endfunction

  task automatic flag_error(input logic [2:0] code);
    if (q_err == V_OK) q_err = code;
  endtask

  task automatic predict_reply(input logic [7:0] b, input logic last);
    int unsigned p;
    logic [7:0]  ob;
    logic [2:0]  v;
    p  = q_pos;
    ob = b;
    if (p < MAX_PACKET) begin
      case (p)
        2: begin
          if ((b & OPCODE_MASK_HI) != 0) flag_error(V_HEADER);
          ob = REPLY_FLAGS[15:8];
        end
        3: ob = REPLY_FLAGS[7:0];
        4: if (b != 8'd0) flag_error(V_HEADER);
        5: if (b != 8'd1) flag_error(V_HEADER);
        6, 8, 9, 10, 11: ob = 8'h00;
        7: ob = 8'h01;
        default: ;
      endcase
      if (p >= HDR_LEN && !q_name_done && q_err == V_OK && p == q_label_at) begin
        if (b == 8'd0) begin
          q_name_done = 1'b1;
          q_name_end  = p;
        end else if ((b & LABEL_PTR_BITS) != 0 || b > LABEL_MAX) begin
          flag_error(V_NAME);
        end else begin
          q_label_at = p + 1 + b;
        end
      end else if (q_name_done && p == q_name_end + 1) begin
        q_type[15:8] = b;
      end else if (q_name_done && p == q_name_end + 2) begin
        q_type[7:0] = b;
      end
      q_pos = p + 1;
    end
    if (!last) begin
      pending_replies.push_back(build_reply(ob, 1'b0, V_OK));
    end else begin
      v = query_verdict(q_pos);
      if (v != V_OK) begin
        pending_replies.push_back(build_reply(ob, 1'b1, v));
      end else begin
        pending_replies.push_back(build_reply(ob, 1'b0, V_OK));
        for (int i = 0; i < ANSWER_LEN; i++)
          pending_replies.push_back(build_reply(answer_field(i), i == ANSWER_LEN - 1, V_OK));
      end
      q_pos       = 0;
      q_label_at  = HDR_LEN;
      q_name_done = 1'b0;
      q_name_end  = 0;
      q_type      = '0;
      q_err       = V_OK;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    query_t q;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    q.in_byte = b;
    q.in_last = last;
    push  <= 1'b1;
    query <= q;
    do @(posedge clk); while (full);
    predict_reply(b, last);
    bytes_sent++;
  endtask

  task automatic send_query();
    for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic start_query(input logic [15:0] flags, input logic [15:0] qdcount);
    pkt.delete();
    pkt.push_back(8'($urandom));
    pkt.push_back(8'($urandom));
    pkt.push_back(flags[15:8]);
    pkt.push_back(flags[7:0]);
    pkt.push_back(qdcount[15:8]);
    pkt.push_back(qdcount[7:0]);
    repeat (6) pkt.push_back(8'($urandom));
  endtask

  task automatic add_label(input logic [7:0] len);
    pkt.push_back(len);
    repeat (len) pkt.push_back(8'($urandom));
  endtask

  task automatic end_name(input logic [15:0] qtype, input int extra);
    pkt.push_back(8'h00);
    pkt.push_back(qtype[15:8]);
    pkt.push_back(qtype[7:0]);
    pkt.push_back(QCLASS_IN[15:8]);
    pkt.push_back(QCLASS_IN[7:0]);
    repeat (extra) pkt.push_back(8'($urandom));
  endtask

  task automatic wait_replies_drained();
    push <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    logic [31:0] rd;
    apb_xfer(1'b1, addr, value, rd);
    if (addr == ADDR_ADDRESS) cfg_address = value;
    else cfg_ttl = value;
    apb_xfer(1'b0, addr, 32'd0, rd);
    if (rd !== value) begin
      $error("prdata[%0d]: expected %08h, got %08h", addr, value, rd);
      mismatches++;
    end
  endtask

  task automatic send_random_query();
    logic [15:0] qt;
    int          trim;
    qt = ($urandom_range(0, 4) == 0) ? 16'($urandom) : QTYPE_A;
    start_query(16'($urandom) & ~OPCODE_FLAGS, 16'd1);
    repeat ($urandom_range(0, 3))
      add_label(($urandom_range(0, 7) == 0) ? 8'($urandom_range(11, 63))
                                            : 8'($urandom_range(1, 10)));
    end_name(qt, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0);
    case ($urandom_range(0, 9))
      0: begin
        pkt.delete();
        repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom));
      end
      1: pkt[2] = pkt[2] | (8'h08 << $urandom_range(0, 3));
      2: begin
        pkt[4] = 8'($urandom);
        pkt[5] = 8'($urandom);
      end
      3: pkt[12] = 8'($urandom_range(64, 255));
      4: begin
        trim = $urandom_range(1, pkt.size() - 1);
        repeat (trim) void'(pkt.pop_back());
      end
      default: ;
    endcase
    send_query();
  endtask

  task automatic send_random_stream(input int items);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < items) send_random_query();
  endtask

  task automatic test_valid_queries();
    start_query(16'h0100, 16'd1);
    end_name(QTYPE_A, 0);
    send_query();
    start_query(16'h87FF, 16'd1);
    add_label(8'd3);
    add_label(8'd7);
    end_name(QTYPE_A, 0);
    send_query();
    wait_replies_drained();
  endtask

  task automatic test_length_limits();
    start_query(16'h0100, 16'd1);
    repeat (3) add_label(LABEL_MAX);
    end_name(QTYPE_A, 31);
    send_query();
    start_query(16'h0100, 16'd1);
    repeat (3) add_label(LABEL_MAX);
    end_name(QTYPE_A, 32);
    send_query();
    start_query(16'h0100, 16'd1);
    end_name(QTYPE_A, 0);
    void'(pkt.pop_back());
    send_query();
    send_byte(8'hFF, 1'b1);
    start_query(16'h7800, 16'd1);
    repeat (9) void'(pkt.pop_back());
    send_query();
    wait_replies_drained();
  endtask

  task automatic test_overlong_packet();
    start_query(16'h0100, 16'd1);
    repeat (3) add_label(LABEL_MAX);
    end_name(QTYPE_A, 51);
    send_query();
    wait_replies_drained();
  endtask

  task automatic test_header_errors();
    start_query(OPCODE_FLAGS, 16'd1);
    end_name(QTYPE_A, 0);
    send_query();
    start_query(16'h0800, 16'd1);
    add_label(8'd4);
    end_name(QTYPE_A, 0);
    send_query();
    start_query(16'h0100, 16'd0);
    end_name(QTYPE_A, 0);
    send_query();
    start_query(16'h0100, 16'h0101);
    end_name(QTYPE_A, 0);
    send_query();
    start_query(16'h0100, 16'd2);
    end_name(QTYPE_A, 0);
    send_query();
    // header error outranks a bad label
    start_query(16'h2000, 16'd1);
    add_label(LABEL_PTR_BITS);
    end_name(QTYPE_A, 0);
    send_query();
    wait_replies_drained();
  endtask

  task automatic test_name_errors();
    start_query(16'h0100, 16'd1);
    add_label(LABEL_PTR_BITS);
    end_name(QTYPE_A, 0);
    send_query();
    start_query(16'h0100, 16'd1);
    add_label(8'h40);
    end_name(QTYPE_A, 0);
    send_query();
    start_query(16'h0100, 16'd1);
    add_label(8'h80);
    end_name(QTYPE_A, 0);
    send_query();
    // label runs past the end of the packet
    start_query(16'h0100, 16'd1);
    add_label(8'd10);
    repeat (6) void'(pkt.pop_back());
    send_query();
    // name never terminated
    start_query(16'h0100, 16'd1);
    repeat (3) add_label(8'd3);
    send_query();
    // class cut off after the type
    start_query(16'h0100, 16'd1);
    add_label(8'd3);
    end_name(QTYPE_A, 0);
    repeat (2) void'(pkt.pop_back());
    send_query();
    wait_replies_drained();
  endtask

  task automatic test_not_a_queries();
    start_query(16'h0100, 16'd1);
    add_label(8'd5);
    end_name(16'd28, 0);
    send_query();
    start_query(16'h0100, 16'd1);
    end_name(16'h0101, 0);
    send_query();
    start_query(16'h0100, 16'd1);
    end_name(16'h0000, 2);
    send_query();
    start_query(16'h0100, 16'd1);
    end_name(16'hFFFF, 0);
    send_query();
    wait_replies_drained();
  endtask

  task automatic test_register_settings();
    write_reg(ADDR_ADDRESS, 32'hFFFF_FFFF);
    write_reg(ADDR_TTL, 32'd0);
    repeat (3) send_random_query();
    start_query(16'h0100, 16'd1);
    end_name(QTYPE_A, 0);
    send_query();
    wait_replies_drained();
    write_reg(ADDR_ADDRESS, 32'd0);
    write_reg(ADDR_TTL, 32'hFFFF_FFFF);
    start_query(16'h0100, 16'd1);
    add_label(8'd2);
    end_name(QTYPE_A, 0);
    send_query();
    repeat (2) send_random_query();
    wait_replies_drained();
  endtask

  task automatic test_random_queries();
    write_reg(ADDR_ADDRESS, $urandom);
    write_reg(ADDR_TTL, $urandom);
    send_random_stream(RANDOM_ITEMS);
    wait_replies_drained();
  endtask

  task automatic test_backpressure();
    tx_idle_en  = 1'b0;
    rx_hold_req = HOLD_CYCLES;
    repeat (3) begin
      start_query(16'h0100, 16'd1);
      add_label(8'd6);
      end_name(QTYPE_A, 0);
      send_query();
    end
    tx_idle_en = 1'b1;
    wait_replies_drained();
  endtask

  task automatic test_quiet_stream();
    write_reg(ADDR_ADDRESS, $urandom);
    write_reg(ADDR_TTL, $urandom);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_random_stream(60);
    wait_replies_drained();
  endtask

  task automatic check_reply();
    reply_t exp;
    if (pending_replies.size() == 0) begin
      $error("unexpected reply: out_byte %02h out_end %0b verdict %0d",
             reply.out_byte, reply.out_end, reply.verdict);
      mismatches++;
    end else begin
      exp = pending_replies.pop_front();
      if (reply.out_byte !== exp.out_byte) begin
        $error("out_byte: expected %02h, got %02h", exp.out_byte, reply.out_byte);
        mismatches++;
      end
      if (reply.out_end !== exp.out_end) begin
        $error("out_end: expected %0b, got %0b", exp.out_end, reply.out_end);
        mismatches++;
      end
      if (reply.verdict !== exp.verdict) begin
        $error("verdict: expected %0d, got %0d", exp.verdict, reply.verdict);
        mismatches++;
      end
    end
  endtask

  // reply side: random stalls plus an occasional long hold
  initial begin
    int hold_left;
    int stall_left;
    hold_left  = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (pop && !empty) check_reply();
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (psel && penable)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("dns_wildcard_a_responder_core regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_valid_queries();
    test_length_limits();
    test_overlong_packet();
    test_header_errors();
    test_name_errors();
    test_not_a_queries();
    test_register_settings();
    test_random_queries();
    test_backpressure();
    test_quiet_stream();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("dns_wildcard_a_responder_core regression: pass");
    end else begin
      $display("dns_wildcard_a_responder_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/dwar_pkg.sv
rtl/core/dwar_front.sv
rtl/core/dwar_queue.sv
rtl/core/dwar_back.sv
rtl/core/dns_wildcard_a_responder_core.sv
tb/dns_wildcard_a_responder_core_tb.sv
